/* design/mwc_pkg.sv */
// shared types and constants for the minimum window cover search
`default_nettype none
package mwc_pkg;

    // input character codes are seven bits wide
    localparam int CODE_W     = 7;
    localparam int CODE_COUNT = 128;

    // operation of the shared need update unit
    typedef enum logic {
        ALU_INC,
        ALU_DEC
    } alu_op_t;

    // status reported by the need update unit
    typedef struct packed {
        logic crossed;   // entry moved across the missing threshold
    } alu_flags_t;

endpackage
`default_nettype wire

/* design/mwc_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module mwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* design/mwc_step_alu.sv */
// shared increment and decrement unit for need table entries
`default_nettype none
module mwc_step_alu #(
    parameter int W = 14
) (
    input  wire mwc_pkg::alu_op_t    op,
    input  wire logic signed [W-1:0] value,
    output logic signed      [W-1:0] value_next,
    output mwc_pkg::alu_flags_t      flags
);

    import mwc_pkg::*;

    logic signed [W-1:0] delta;

    always_comb
    begin
        delta      = (op == ALU_DEC) ? -W'(1) : W'(1);
        value_next = value + delta;
        // inc counts when the entry goes positive, dec when it stays non-negative
        if (op == ALU_DEC)
        begin
            flags.crossed = !value_next[W-1];
        end
        else
        begin
            flags.crossed = !value_next[W-1] && (value_next != '0);
        end
    end

endmodule
`default_nettype wire

/* design/min_window_cover_search.sv */
// top level of the minimum window cover search
//
// Finds the shortest stretch of a streamed text that holds every pattern
// character with its multiplicity. A job is pattern requests (mode 0), text
// requests (mode 1) and one finish request (mode 2), which returns found,
// win_start, win_length and overflow and then starts a fresh job. Mode 3 is
// dropped. Character codes fold modulo CHARSET; requests beyond MAX_TEXT are
// dropped and raise overflow. A pattern request reads its need table entry,
// then updates it and writes it back. A text request does the same, then for
// every character that leaves the left edge of the window (each leaves once
// over a job) fetches it from the text buffer, reads, updates and writes back
// its entry. A finish, mode 3 or dropped request is handled in the idle state.
// These steps come from the single shared need update unit and the
// registered read of the need table and the text buffer. The need table
// is cleared at once by per-entry valid bits, so there is no clearing pass
// after reset or after a finish. A pattern or text request is taken while a
// result still waits on the output; a finish request waits until the output
// register is free.
`default_nettype none
module min_window_cover_search #(
    parameter int MAX_TEXT = 4096,
    parameter int CHARSET  = 128
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire logic [1:0]                   mode,
    input  wire logic [mwc_pkg::CODE_W-1:0]   char_code,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output logic                              found,
    output logic [11:0]                       win_start,
    output logic [12:0]                       win_length,
    output logic                              overflow
);

    import mwc_pkg::*;

    // widths: positions and counts reach MAX_TEXT, need entries are signed
    localparam int PW = $clog2(MAX_TEXT + 1);
    localparam int AW = $clog2(MAX_TEXT);
    localparam int NW = PW + 1;
    localparam int CW = $clog2(CHARSET);
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_TEXT);

    // request modes
    localparam logic [1:0] MODE_PATTERN = 2'd0;
    localparam logic [1:0] MODE_TEXT    = 2'd1;
    localparam logic [1:0] MODE_FINISH  = 2'd2;

    // sequencer states
    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_NEED_RD    = 3'd1;
    localparam logic [2:0] S_NEED_WR    = 3'd2;
    localparam logic [2:0] S_SHRINK_CHK = 3'd3;
    localparam logic [2:0] S_TXT_WAIT   = 3'd4;
    localparam logic [2:0] S_SHRINK_WR  = 3'd5;

    // code folding table, worked out at elaboration
    logic [CW-1:0] fold_lut [CODE_COUNT];

    for (genvar i = 0; i < CODE_COUNT; i++)
    begin : g_fold
        localparam int FOLD = i % CHARSET;
        assign fold_lut[i] = FOLD[CW-1:0];
    end

    // sequencer and job state
    logic [2:0]         state_reg, state_next;
    logic               is_text_reg, is_text_next;
    logic [CW-1:0]      c_reg, c_next;
    logic [PW-1:0]      pcount_reg, pcount_next;
    logic [PW-1:0]      missing_reg, missing_next;
    logic [PW-1:0]      left_reg, left_next;
    logic [PW-1:0]      right_reg, right_next;
    logic [AW-1:0]      best_start_reg, best_start_next;
    logic [PW-1:0]      best_len_reg, best_len_next;
    logic               found_reg, found_next;
    logic               ovf_reg, ovf_next;
    logic [CHARSET-1:0] need_valid_reg, need_valid_next;

    // output register
    logic               result_valid_reg, result_valid_next;
    logic               res_found_reg, res_found_next;
    logic [11:0]        res_start_reg, res_start_next;
    logic [12:0]        res_len_reg, res_len_next;
    logic               res_ovf_reg, res_ovf_next;

    // memory ports
    logic               need_wr_en;
    logic               need_rd_en;
    logic [CW-1:0]      need_rd_addr;
    logic [NW-1:0]      need_rdata;
    logic               txt_wr_en;
    logic               txt_rd_en;
    logic [CODE_W-1:0]  txt_rdata;

    // shared update unit
    alu_op_t            alu_op;
    logic signed [NW-1:0] need_cur;
    logic signed [NW-1:0] need_upd;
    alu_flags_t         alu_flags;

    logic               item_fire;
    logic [CW-1:0]      in_code;
    logic [CW-1:0]      txt_code;
    logic [PW-1:0]      win_len;
    logic               shrink_go;

    assign item_ready = (state_reg == S_IDLE)
                        && (!result_valid_reg || result_ready || (mode != MODE_FINISH));
    assign item_fire  = item_valid && item_ready;
    assign in_code    = fold_lut[char_code];
    assign txt_code   = fold_lut[txt_rdata];

    // an entry never written in this job reads as zero
    assign need_cur   = need_valid_reg[c_reg] ? $signed(need_rdata) : '0;
    assign alu_op     = (state_reg == S_NEED_WR && is_text_reg) ? ALU_DEC : ALU_INC;

    assign win_len    = right_reg - left_reg;
    assign shrink_go  = (missing_reg == '0) && (left_reg < right_reg);

    assign need_rd_en   = (state_reg == S_NEED_RD) || (state_reg == S_TXT_WAIT);
    assign need_rd_addr = (state_reg == S_TXT_WAIT) ? txt_code : c_reg;
    assign need_wr_en   = (state_reg == S_NEED_WR) || (state_reg == S_SHRINK_WR);
    assign txt_wr_en    = (state_reg == S_NEED_RD) && is_text_reg;
    assign txt_rd_en    = (state_reg == S_SHRINK_CHK) && shrink_go;

    mwc_step_alu #(
        .W (NW)
    ) u_alu (
        .op         (alu_op),
        .value      (need_cur),
        .value_next (need_upd),
        .flags      (alu_flags)
    );

    // signed need count per character
    mwc_ram #(
        .WIDTH (NW),
        .DEPTH (CHARSET)
    ) u_need_ram (
        .clk     (clk),
        .wr_en   (need_wr_en),
        .wr_addr (c_reg),
        .wr_data (need_upd),
        .rd_en   (need_rd_en),
        .rd_addr (need_rd_addr),
        .rd_data (need_rdata)
    );

    // buffered text, needed again when characters leave the window
    mwc_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_TEXT)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (txt_wr_en),
        .wr_addr (right_reg[AW-1:0]),
        .wr_data (CODE_W'(c_reg)),
        .rd_en   (txt_rd_en),
        .rd_addr (left_reg[AW-1:0]),
        .rd_data (txt_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        is_text_next      = is_text_reg;
        c_next            = c_reg;
        pcount_next       = pcount_reg;
        missing_next      = missing_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        best_start_next   = best_start_reg;
        best_len_next     = best_len_reg;
        found_next        = found_reg;
        ovf_next          = ovf_reg;
        need_valid_next   = need_valid_reg;
        result_valid_next = result_valid_reg && !result_ready;
        res_found_next    = res_found_reg;
        res_start_next    = res_start_reg;
        res_len_next      = res_len_reg;
        res_ovf_next      = res_ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    c_next = in_code;
                    unique case (mode)
                        MODE_PATTERN:
                        begin
                            if (pcount_reg >= MAX_POS)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                pcount_next  = pcount_reg + PW'(1);
                                is_text_next = 1'b0;
                                state_next   = S_NEED_RD;
                            end
                        end
                        MODE_TEXT:
                        begin
                            if (right_reg >= MAX_POS)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                // empty pattern: the empty window at the start covers it
                                if (right_reg == '0 && missing_reg == '0 && !found_reg)
                                begin
                                    found_next      = 1'b1;
                                    best_len_next   = '0;
                                    best_start_next = '0;
                                end
                                is_text_next = 1'b1;
                                state_next   = S_NEED_RD;
                            end
                        end
                        MODE_FINISH:
                        begin
                            result_valid_next = 1'b1;
                            res_found_next    = found_reg;
                            res_start_next    = found_reg ? 12'(best_start_reg) : '0;
                            res_len_next      = found_reg ? 13'(best_len_reg) : '0;
                            res_ovf_next      = ovf_reg;
                            // fresh job
                            pcount_next       = '0;
                            missing_next      = '0;
                            left_next         = '0;
                            right_next        = '0;
                            best_start_next   = '0;
                            best_len_next     = '0;
                            found_next        = 1'b0;
                            ovf_next          = 1'b0;
                            need_valid_next   = '0;
                        end
                        default:
                        begin
                            // unused mode, dropped
                        end
                    endcase
                end
            end
            S_NEED_RD:
            begin
                state_next = S_NEED_WR;
            end
            S_NEED_WR:
            begin
                need_valid_next[c_reg] = 1'b1;
                if (is_text_reg)
                begin
                    if (alu_flags.crossed)
                    begin
                        missing_next = missing_reg - PW'(1);
                    end
                    right_next = right_reg + PW'(1);
                    state_next = S_SHRINK_CHK;
                end
                else
                begin
                    missing_next = missing_reg + PW'(1);
                    state_next   = S_IDLE;
                end
            end
            S_SHRINK_CHK:
            begin
                if (shrink_go)
                begin
                    if (!found_reg || win_len < best_len_reg)
                    begin
                        found_next      = 1'b1;
                        best_len_next   = win_len;
                        best_start_next = left_reg[AW-1:0];
                    end
                    state_next = S_TXT_WAIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TXT_WAIT:
            begin
                c_next     = txt_code;
                state_next = S_SHRINK_WR;
            end
            S_SHRINK_WR:
            begin
                need_valid_next[c_reg] = 1'b1;
                if (alu_flags.crossed)
                begin
                    missing_next = missing_reg + PW'(1);
                end
                left_next  = left_reg + PW'(1);
                state_next = S_SHRINK_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            is_text_reg      <= 1'b0;
            pcount_reg       <= '0;
            missing_reg      <= '0;
            left_reg         <= '0;
            right_reg        <= '0;
            best_start_reg   <= '0;
            best_len_reg     <= '0;
            found_reg        <= 1'b0;
            ovf_reg          <= 1'b0;
            need_valid_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            is_text_reg      <= is_text_next;
            pcount_reg       <= pcount_next;
            missing_reg      <= missing_next;
            left_reg         <= left_next;
            right_reg        <= right_next;
            best_start_reg   <= best_start_next;
            best_len_reg     <= best_len_next;
            found_reg        <= found_next;
            ovf_reg          <= ovf_next;
            need_valid_reg   <= need_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        c_reg         <= c_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
        res_len_reg   <= res_len_next;
        res_ovf_reg   <= res_ovf_next;
    end

    assign result_valid = result_valid_reg;
    assign found        = res_found_reg;
    assign win_start    = res_start_reg;
    assign win_length   = res_len_reg;
    assign overflow     = res_ovf_reg;

    // the window never inverts
    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= right_reg)
        else $error("left edge passed right edge");

    // missing characters never exceed the pattern length
    a_missing_bound: assert property (@(posedge clk) disable iff (!rst_n)
        missing_reg <= pcount_reg)
        else $error("missing count exceeds pattern count");

    // a recorded window fits inside the text seen so far
    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_len_reg <= right_reg))
        else $error("best window longer than text");

    // a finish request starts a fresh job
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && mode == MODE_FINISH)
        |=> (right_reg == '0 && pcount_reg == '0 && !found_reg && result_valid_reg))
        else $error("job state not cleared after finish");

endmodule
`default_nettype wire

/* sim/min_window_cover_checker.sv */
// request codes and the scoreboard checker for the minimum window cover search
`timescale 1ns / 100ps

package mwc_tb_pkg;

    typedef enum logic [1:0] {
        MODE_PATTERN = 2'd0,
        MODE_TEXT    = 2'd1,
        MODE_FINISH  = 2'd2,
        MODE_UNUSED  = 2'd3
    } req_mode_t;

    typedef struct packed {
        logic        found;
        logic [11:0] start;
        logic [12:0] length;
        logic        ovf;
    } window_result_t;

    localparam int TEXT_DEPTH = 4096;

endpackage

module min_window_cover_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [1:0]  mode,
    input  logic [6:0]  char_code,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic        found,
    input  logic [11:0] win_start,
    input  logic [12:0] win_length,
    input  logic        overflow,
    output int          fail_count,
    output int          outstanding
);

    import mwc_tb_pkg::*;

    localparam int CODE_SPACE = mwc_pkg::CODE_COUNT;

    // own copy of the job state
    int             need_count [CODE_SPACE];
    logic [6:0]     text_buf [TEXT_DEPTH];
    int             missing;
    int             left_edge;
    int             right_edge;
    int             best_start;
    int             best_len;
    logic           window_seen;
    logic           overflow_seen;
    int             pattern_total;
    window_result_t expected_windows [$];

    task automatic clear_job();
        foreach (need_count[i])
            need_count[i] = 0;
        missing       = 0;
        left_edge     = 0;
        right_edge    = 0;
        best_start    = 0;
        best_len      = 0;
        window_seen   = 1'b0;
        overflow_seen = 1'b0;
        pattern_total = 0;
    endtask

    task automatic track_request(input req_mode_t req, input logic [6:0] code);
        int             len;
        logic [6:0]     gone;
        window_result_t res;
        case (req)
            MODE_PATTERN:
            begin
                if (pattern_total >= TEXT_DEPTH)
                    overflow_seen = 1'b1;
                else
                begin
                    pattern_total++;
                    need_count[code]++;
                    missing++;
                end
            end
            MODE_TEXT:
            begin
                if (right_edge >= TEXT_DEPTH)
                    overflow_seen = 1'b1;
                else
                begin
                    // empty pattern: the empty window at 0 counts
                    if (right_edge == 0 && missing == 0 && !window_seen)
                    begin
                        window_seen = 1'b1;
                        best_len    = 0;
                        best_start  = 0;
                    end
                    text_buf[right_edge] = code;
                    need_count[code]--;
                    if (need_count[code] >= 0)
                        missing--;
                    right_edge++;
                    // pull the left edge in while the window still covers
                    while (missing == 0 && left_edge < right_edge)
                    begin
                        len = right_edge - left_edge;
                        if (!window_seen || len < best_len)
                        begin
                            window_seen = 1'b1;
                            best_len    = len;
                            best_start  = left_edge;
                        end
                        gone = text_buf[left_edge];
                        need_count[gone]++;
                        if (need_count[gone] > 0)
                            missing++;
                        left_edge++;
                    end
                end
            end
            MODE_FINISH:
            begin
                res.found  = window_seen;
                res.start  = window_seen ? best_start[11:0] : 12'd0;
                res.length = window_seen ? best_len[12:0] : 13'd0;
                res.ovf    = overflow_seen;
                expected_windows.push_back(res);
                clear_job();
            end
            default:
                ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t want;
        if (!rst_n)
        begin
            clear_job();
            expected_windows.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                track_request(req_mode_t'(mode), char_code);
            if (result_valid && result_ready)
            begin
                if (expected_windows.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d %0d %0d %0d",
                             $time, found, win_start, win_length, overflow);
                    fail_count++;
                end
                else
                begin
                    want = expected_windows.pop_front();
                    check_field("found", 13'(want.found), 13'(found));
                    check_field("win_start", 13'(want.start), 13'(win_start));
                    check_field("win_length", want.length, win_length);
                    check_field("overflow", 13'(want.ovf), 13'(overflow));
                end
            end
            outstanding <= expected_windows.size();
        end
    end

endmodule

/* sim/tb_min_window_cover_search.sv */
// testbench top for the minimum window cover search: stimulus, handshakes and verdict
`timescale 1ns / 100ps

module tb_min_window_cover_search;

    import mwc_tb_pkg::*;

    // random stimulus budget, counted in requests that the block acts on
    localparam int RANDOM_ITEMS = 1500;
    // far above the slowest correct run, long buffer jobs included
    localparam int CYCLE_LIMIT  = 2_000_000;
    // settle time after the last result
    localparam int TAIL_CYCLES  = 40;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         item_valid = 1'b0;
    logic                         item_ready;
    logic [1:0]                   mode = 2'd0;
    logic [mwc_pkg::CODE_W-1:0]   char_code = '0;
    logic                         result_valid;
    logic                         result_ready = 1'b0;
    logic                         found;
    logic [11:0]                  win_start;
    logic [12:0]                  win_length;
    logic                         overflow;
    int                           fail_count;
    int                           outstanding;

    // idling knobs, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent_items = 0;
    int cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    min_window_cover_search DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .char_code    (char_code),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .found        (found),
        .win_start    (win_start),
        .win_length   (win_length),
        .overflow     (overflow)
    );

    // watches both channels, predicts every finish result and compares
    min_window_cover_checker u_checker (.*);

    // receiver stalls at random, rate set by the current phase
    always @(posedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one request: optional idle gap, then hold valid until accepted;
    // valid only drops when a gap is taken, so back to back requests keep it high
    task automatic send_req(input req_mode_t m, input logic [6:0] c);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        mode       <= m;
        char_code  <= c;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (m != MODE_UNUSED)
            sent_items++;
    endtask

    // sender holds off until every expected result has come back
    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // a code from the small alphabet of the current job
    function automatic logic [6:0] job_char(input int base, input int span);
        return 7'((base + $urandom_range(0, span - 1)) % 128);
    endfunction

    // any code except the two marker characters
    function automatic logic [6:0] filler(input logic [6:0] a, input logic [6:0] b);
        logic [6:0] c;
        do
            c = 7'($urandom_range(0, 127));
        while (c == a || c == b);
        return c;
    endfunction

    // mostly a well-formed job over a narrow alphabet so windows really close;
    // noise: dropped mode 3 requests, pattern characters after text,
    // stray codes and now and then a missing finish that merges two jobs
    task automatic random_job();
        int pat_len;
        int txt_len;
        int base;
        int span;
        int roll;
        pat_len = $urandom_range(0, 6);
        txt_len = $urandom_range(0, 32);
        base    = $urandom_range(0, 127);
        span    = $urandom_range(1, 5);
        for (int i = 0; i < pat_len; i++)
            send_req(MODE_PATTERN, job_char(base, span));
        for (int i = 0; i < txt_len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_req(MODE_UNUSED, 7'($urandom));
            else if (roll < 8)
                send_req(MODE_PATTERN, job_char(base, span));
            else if (roll < 12)
                send_req(MODE_TEXT, 7'($urandom));
            else
                send_req(MODE_TEXT, job_char(base, span));
        end
        if ($urandom_range(0, 19) != 0)
            send_req(MODE_FINISH, 7'($urandom));
    endtask

    initial
    begin
        logic [6:0] a;
        logic [6:0] b;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: nothing at all, then empty pattern with one text character
        send_req(MODE_FINISH, 7'd127);
        send_req(MODE_TEXT, 7'd65);
        send_req(MODE_FINISH, 7'd0);
        // unused mode is dropped
        send_req(MODE_UNUSED, 7'd127);
        // extreme codes in pattern and text
        send_req(MODE_PATTERN, 7'd0);
        send_req(MODE_PATTERN, 7'd127);
        send_req(MODE_TEXT, 7'd127);
        send_req(MODE_TEXT, 7'd5);
        send_req(MODE_TEXT, 7'd0);
        send_req(MODE_FINISH, 7'd85);
        // repeated character in the pattern, then a pattern character after text
        send_req(MODE_PATTERN, 7'd97);
        send_req(MODE_PATTERN, 7'd97);
        send_req(MODE_PATTERN, 7'd98);
        send_req(MODE_TEXT, 7'd98);
        send_req(MODE_TEXT, 7'd97);
        send_req(MODE_TEXT, 7'd97);
        send_req(MODE_PATTERN, 7'd99);
        send_req(MODE_TEXT, 7'd98);
        send_req(MODE_TEXT, 7'd99);
        send_req(MODE_FINISH, 7'd42);
        // no cover in the text
        send_req(MODE_PATTERN, 7'd122);
        send_req(MODE_TEXT, 7'd121);
        send_req(MODE_FINISH, 7'd1);

        // widest window: markers at both ends of a full buffer, then text overflow
        a = 7'($urandom_range(0, 127));
        b = 7'((a + $urandom_range(1, 127)) % 128);
        send_req(MODE_PATTERN, a);
        send_req(MODE_PATTERN, b);
        send_req(MODE_TEXT, a);
        for (int i = 1; i < TEXT_DEPTH - 1; i++)
            send_req(MODE_TEXT, filler(a, b));
        send_req(MODE_TEXT, b);
        repeat (3) send_req(MODE_TEXT, b);
        send_req(MODE_FINISH, 7'd0);

        // window at the very last buffer position, buffer exactly full
        send_req(MODE_PATTERN, b);
        for (int i = 0; i < TEXT_DEPTH - 1; i++)
            send_req(MODE_TEXT, filler(a, b));
        send_req(MODE_TEXT, b);
        send_req(MODE_FINISH, 7'd0);

        // pattern overflow, with a little text behind it
        for (int i = 0; i < TEXT_DEPTH + 4; i++)
            send_req(MODE_PATTERN, job_char(a, 3));
        for (int i = 0; i < 6; i++)
            send_req(MODE_TEXT, job_char(a, 3));
        send_req(MODE_FINISH, 7'd0);

        // random part in four idling phases, each opened by a full drain
        sent_items = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 70;
                end
                default:
                begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            drain_results();
            while (sent_items < (ph + 1) * RANDOM_ITEMS / 4)
                random_job();
        end
        // close whatever job is open
        send_req(MODE_FINISH, 7'($urandom));

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
